[sv/pitc_pkg.sv]
// Shared types, codes and constants of the three-channel interval timer.
package pitc_pkg;

  localparam int MAX_CH       = 3;
  localparam int NUM_CHANNELS = 3;

  localparam logic       OP_ACCESS    = 1'b0;
  localparam logic       OP_TICK      = 1'b1;
  localparam logic [2:0] PORT_CNT0    = 3'd0;
  localparam logic [2:0] PORT_CNT1    = 3'd1;
  localparam logic [2:0] PORT_CNT2    = 3'd2;
  localparam logic [2:0] PORT_CTRL    = 3'd3;
  localparam logic [2:0] PORT_MISC    = 3'd4;
  localparam logic [1:0] SEL_READBACK = 2'd3;
  localparam logic [1:0] ACC_LATCH    = 2'b00;
  localparam logic [2:0] MODE_ONESHOT = 3'd0;
  localparam logic [2:0] MODE_SQUARE  = 3'd3;

  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [7:0]  STATUS_BASE = 8'h30;
  localparam logic [7:0]  MISC_FIRED  = 8'h20;

  // Per-channel command for the item in the work stage.
  typedef struct packed {
    logic       tick;
    logic       wr_cnt;
    logic       rd_cnt;
    logic       latch;
    logic       set_status;
    logic       set_mode;
    logic [7:0] data;
  } chan_cmd_t;

  // Per-channel view back to the top level.
  typedef struct packed {
    logic [7:0]  rd_data;
    logic        fire;
    logic [2:0]  mode;
    logic        fired;
    logic [15:0] count;
    logic [15:0] reload;
  } chan_stat_t;

endpackage

[sv/interval_timer_three_channel_core.sv]
// Top level of the three-channel interval timer: input stage, decode, result register.
// An accepted item passes the input register, then the result register; the channel
// counters update on the same edge the result is loaded. Throughput: one item per cycle
// while out_tready takes results; the per-channel decrement and compare fit in one stage.
// Reset (rst_n low, synchronous): pipeline empties, every channel returns to count 65535,
// reload 65535, mode 0, unarmed, with read and write byte order back at the low byte.
module interval_timer_three_channel_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] port, [3] is_write, [11:4] write_byte, [15:12] zero
  input  logic [0:0]  in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] read_byte, [8] irq_pulse, [15:9] zero
);

  logic       v1_r;
  logic       op_r;
  logic [2:0] port_r;
  logic       wr_r;
  logic [7:0] byte_r;
  logic       out_valid_r;
  logic [7:0] rd_r, rd_nxt;
  logic       irq_r, irq_nxt;
  logic       adv, step, in_acc;
  logic       acc, ctrl_wr;
  logic [1:0] sel;
  logic [7:0] misc;

  pitc_pkg::chan_cmd_t  cmd  [pitc_pkg::MAX_CH];
  pitc_pkg::chan_stat_t stat [pitc_pkg::MAX_CH];

  assign adv       = !out_valid_r || out_tready;
  assign step      = v1_r && adv;
  assign in_tready = !v1_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        v1_r <= 1'b1;
      end else if (adv) begin
        v1_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_tuser[0];
      port_r <= in_tdata[2:0];
      wr_r   <= in_tdata[3];
      byte_r <= in_tdata[11:4];
    end
    if (step) begin
      rd_r  <= rd_nxt;
      irq_r <= irq_nxt;
    end
  end

  assign acc     = step && (op_r == pitc_pkg::OP_ACCESS);
  assign ctrl_wr = acc && (port_r == pitc_pkg::PORT_CTRL) && wr_r;
  assign sel     = byte_r[7:6];

  for (genvar ch = 0; ch < pitc_pkg::MAX_CH; ch++) begin : g_ch
    if (ch < pitc_pkg::NUM_CHANNELS) begin : g_on
      logic rb, mine;
      assign rb   = (sel == pitc_pkg::SEL_READBACK) && byte_r[ch+1];
      assign mine = (sel == 2'(ch));
      always_comb begin
        cmd[ch].tick       = step && (op_r == pitc_pkg::OP_TICK);
        cmd[ch].wr_cnt     = acc && (port_r == 3'(ch)) && wr_r;
        cmd[ch].rd_cnt     = acc && (port_r == 3'(ch)) && !wr_r;
        cmd[ch].latch      = ctrl_wr && ((rb && !byte_r[5]) ||
                             (mine && byte_r[5:4] == pitc_pkg::ACC_LATCH));
        cmd[ch].set_status = ctrl_wr && rb && !byte_r[4];
        cmd[ch].set_mode   = ctrl_wr && mine && (byte_r[5:4] != pitc_pkg::ACC_LATCH);
        cmd[ch].data       = byte_r;
      end
      pitc_chan u_chan (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd[ch]),
        .stat (stat[ch])
      );
    end else begin : g_off
      assign cmd[ch]  = '0;
      assign stat[ch] = '0;
    end
  end

  always_comb begin
    misc = 8'd0;
    if (pitc_pkg::NUM_CHANNELS > 2) begin
      if (stat[2].mode == pitc_pkg::MODE_ONESHOT) begin
        misc = stat[2].fired ? pitc_pkg::MISC_FIRED : 8'd0;
      end else if (stat[2].mode == pitc_pkg::MODE_SQUARE) begin
        misc = {7'd0, stat[2].count > {1'b0, stat[2].reload[15:1]}};
      end
    end
  end

  always_comb begin
    rd_nxt  = 8'd0;
    irq_nxt = 1'b0;
    if (op_r == pitc_pkg::OP_TICK) begin
      irq_nxt = stat[0].fire;
    end else if (!wr_r) begin
      unique case (port_r)
        pitc_pkg::PORT_CNT0: rd_nxt = stat[0].rd_data;
        pitc_pkg::PORT_CNT1: rd_nxt = stat[1].rd_data;
        pitc_pkg::PORT_CNT2: rd_nxt = stat[2].rd_data;
        pitc_pkg::PORT_MISC: rd_nxt = misc;
        default:             rd_nxt = 8'd0;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, irq_r, rd_r};

endmodule

[sv/pitc_chan.sv]
// One timer channel: counter, reload, mode, latch and byte sequencing.
module pitc_chan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pitc_pkg::chan_cmd_t  cmd,
  output pitc_pkg::chan_stat_t stat
);

  logic [15:0] reload_r, reload_nxt;
  logic [15:0] count_r, count_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        exp_hi_r, exp_hi_nxt;
  logic        exp_lo_rd_r, exp_lo_rd_nxt;
  logic [15:0] latch_r, latch_nxt;
  logic        pend_r, pend_nxt;
  logic        fired_r, fired_nxt;
  logic        armed_r, armed_nxt;
  logic        fire;
  logic [7:0]  rd_data;
  logic [15:0] new_reload;

  always_comb begin
    reload_nxt    = reload_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    hold_nxt      = hold_r;
    exp_hi_nxt    = exp_hi_r;
    exp_lo_rd_nxt = exp_lo_rd_r;
    latch_nxt     = latch_r;
    pend_nxt      = pend_r;
    fired_nxt     = fired_r;
    armed_nxt     = armed_r;
    fire          = 1'b0;
    rd_data       = 8'd0;
    new_reload    = {cmd.data, hold_r};
    if (new_reload == 16'd0) begin
      new_reload = pitc_pkg::COUNT_MAX;
    end

    if (cmd.tick) begin
      if (count_r > 16'd1) begin
        count_nxt = count_r - 16'd1;
      end else begin
        // wrap to reload; fire only once loaded
        count_nxt = reload_r;
        if (armed_r) begin
          fire = 1'b1;
          if (mode_r == pitc_pkg::MODE_ONESHOT) begin
            fired_nxt = 1'b1;
            armed_nxt = 1'b0;
          end
        end
      end
    end

    if (cmd.wr_cnt) begin
      if (!exp_hi_r) begin
        hold_nxt   = cmd.data;
        exp_hi_nxt = 1'b1;
      end else begin
        reload_nxt = new_reload;
        count_nxt  = new_reload;
        hold_nxt   = 8'd0;
        exp_hi_nxt = 1'b0;
        fired_nxt  = 1'b0;
        armed_nxt  = 1'b1;
      end
    end

    if (cmd.rd_cnt) begin
      if (pend_r) begin
        pend_nxt = 1'b0;
        rd_data  = pitc_pkg::STATUS_BASE | {4'd0, mode_r, 1'b0};
      end else if (exp_lo_rd_r) begin
        rd_data       = latch_r[7:0];
        exp_lo_rd_nxt = 1'b0;
      end else begin
        rd_data       = latch_r[15:8];
        exp_lo_rd_nxt = 1'b1;
      end
    end

    if (cmd.latch) begin
      latch_nxt = count_r;
    end
    if (cmd.set_status) begin
      pend_nxt = 1'b1;
    end
    if (cmd.set_mode) begin
      mode_nxt = cmd.data[3:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r    <= pitc_pkg::COUNT_MAX;
      count_r     <= pitc_pkg::COUNT_MAX;
      mode_r      <= pitc_pkg::MODE_ONESHOT;
      hold_r      <= 8'd0;
      exp_hi_r    <= 1'b0;
      exp_lo_rd_r <= 1'b1;
      latch_r     <= 16'd0;
      pend_r      <= 1'b0;
      fired_r     <= 1'b0;
      armed_r     <= 1'b0;
    end else begin
      reload_r    <= reload_nxt;
      count_r     <= count_nxt;
      mode_r      <= mode_nxt;
      hold_r      <= hold_nxt;
      exp_hi_r    <= exp_hi_nxt;
      exp_lo_rd_r <= exp_lo_rd_nxt;
      latch_r     <= latch_nxt;
      pend_r      <= pend_nxt;
      fired_r     <= fired_nxt;
      armed_r     <= armed_nxt;
    end
  end

  always_comb begin
    stat.rd_data = rd_data;
    stat.fire    = fire;
    stat.mode    = mode_r;
    stat.fired   = fired_r;
    stat.count   = count_r;
    stat.reload  = reload_r;
  end

endmodule

[sv/pitc_checker.sv]
// Port-level checker for the interval timer core, bound to the top level.
module pitc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[7:0] == 8'd0)
    else $error("irq item carries read data");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:9] == 7'd0)
    else $error("result padding not zero");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("accepted item did not reach the output");

endmodule

bind interval_timer_three_channel_core pitc_checker u_pitc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

[tb/sv/tb.sv]
// Self-checking testbench for interval_timer_three_channel_core.
module tb;

  localparam logic       DIR_RD   = 1'b0;
  localparam logic       DIR_WR   = 1'b1;
  localparam logic [1:0] ACC_LOHI = 2'b11;
  localparam int         N_RANDOM = 1000;

  typedef struct packed {
    logic       op;
    logic [2:0] port;
    logic       is_wr;
    logic [7:0] data;
  } pit_item_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
  } pit_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [2:0] port, [3] is_write, [11:4] write_byte, [15:12] zero
  logic [0:0]  in_tuser;   // [0] operation
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] read_byte, [8] irq_pulse, [15:9] zero

  interval_timer_three_channel_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Predictor copy of the timer state
  logic [15:0] reload_q   [pitc_pkg::MAX_CH];
  logic [15:0] count_q    [pitc_pkg::MAX_CH];
  logic [2:0]  mode_q     [pitc_pkg::MAX_CH];
  logic [7:0]  lsb_hold   [pitc_pkg::MAX_CH];
  logic        want_msb   [pitc_pkg::MAX_CH];
  logic        want_lsb   [pitc_pkg::MAX_CH];
  logic [15:0] snap_q     [pitc_pkg::MAX_CH];
  logic        status_due [pitc_pkg::MAX_CH];
  logic        fired_q    [pitc_pkg::MAX_CH];
  logic        armed_q    [pitc_pkg::MAX_CH];

  pit_item_t   pending_items[$];
  pit_result_t due_results[$];
  int          n_sent;
  int          n_accepted;
  int          err_cnt;
  int          bound1;
  int          bound2;
  bit          in_taken;

  function automatic pit_result_t timer_apply(pit_item_t it);
    pit_result_t r;
    logic [15:0] word;
    logic [1:0]  sel;
    int          c;
    r = '0;
    sel = it.data[7:6];
    c = int'(it.port);
    if (it.op == pitc_pkg::OP_TICK) begin
      for (int ch = 0; ch < pitc_pkg::NUM_CHANNELS; ch++) begin
        if (count_q[ch] > 16'd1) begin
          count_q[ch] = count_q[ch] - 16'd1;
        end else begin
          count_q[ch] = reload_q[ch];
          if (armed_q[ch]) begin
            if (ch == 0) r.irq = 1'b1;
            // one-shot: flag and disarm until the next load
            if (mode_q[ch] == pitc_pkg::MODE_ONESHOT) begin
              fired_q[ch] = 1'b1;
              armed_q[ch] = 1'b0;
            end
          end
        end
      end
    end else if (it.port < pitc_pkg::PORT_CTRL) begin
      if (c < pitc_pkg::NUM_CHANNELS) begin
        if (it.is_wr == DIR_WR) begin
          if (!want_msb[c]) begin
            lsb_hold[c] = it.data;
            want_msb[c] = 1'b1;
          end else begin
            word = {it.data, lsb_hold[c]};
            if (word == 16'd0) word = pitc_pkg::COUNT_MAX;
            reload_q[c] = word;
            count_q[c]  = word;
            lsb_hold[c] = 8'd0;
            want_msb[c] = 1'b0;
            fired_q[c]  = 1'b0;
            armed_q[c]  = 1'b1;
          end
        end else if (status_due[c]) begin
          status_due[c] = 1'b0;
          r.rd = pitc_pkg::STATUS_BASE | {4'd0, mode_q[c], 1'b0};
        end else if (want_lsb[c]) begin
          r.rd = snap_q[c][7:0];
          want_lsb[c] = 1'b0;
        end else begin
          r.rd = snap_q[c][15:8];
          want_lsb[c] = 1'b1;
        end
      end
    end else if (it.port == pitc_pkg::PORT_CTRL) begin
      if (it.is_wr == DIR_WR) begin
        if (sel == pitc_pkg::SEL_READBACK) begin
          // enable bits are active low; channel mask in bits 3:1
          for (int ch = 0; ch < pitc_pkg::NUM_CHANNELS; ch++) begin
            if (it.data[ch+1]) begin
              if (!it.data[5]) snap_q[ch] = count_q[ch];
              if (!it.data[4]) status_due[ch] = 1'b1;
            end
          end
        end else if (sel < pitc_pkg::NUM_CHANNELS) begin
          if (it.data[5:4] == pitc_pkg::ACC_LATCH) snap_q[sel] = count_q[sel];
          else mode_q[sel] = it.data[3:1];
        end
      end
    end else if (it.port == pitc_pkg::PORT_MISC) begin
      if (it.is_wr == DIR_RD && pitc_pkg::NUM_CHANNELS > 2) begin
        if (mode_q[2] == pitc_pkg::MODE_ONESHOT) begin
          r.rd = fired_q[2] ? pitc_pkg::MISC_FIRED : 8'd0;
        end else if (mode_q[2] == pitc_pkg::MODE_SQUARE) begin
          r.rd = (count_q[2] > (reload_q[2] >> 1)) ? 8'd1 : 8'd0;
        end
      end
    end
    return r;
  endfunction

  function automatic void put(logic op, logic [2:0] port, logic wr, logic [7:0] b);
    pit_item_t it;
    it = '{op: op, port: port, is_wr: wr, data: b};
    pending_items.push_back(it);
  endfunction

  function automatic logic [7:0] ctrl_word(logic [1:0] sel, logic [1:0] acc, logic [2:0] md);
    return {sel, acc, md, 1'(($urandom))};
  endfunction

  function automatic void put_tick();
    put(pitc_pkg::OP_TICK, 3'($urandom), 1'($urandom), 8'($urandom));
  endfunction

  task automatic flag_mismatch(string what, int want, int got);
    err_cnt++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  always #6 clk = ~clk;

  // Driver: present queued items at the falling edge
  always @(negedge clk) begin : drive
    int        idle_in;
    int        idle_out;
    pit_item_t nxt;
    idle_in  = (n_sent < bound1) ? 28 : (n_sent < bound2) ? 76 : 0;
    idle_out = (n_sent < bound1) ? 76 : (n_sent < bound2) ? 28 : 0;
    out_tready <= rst_n && ($urandom_range(0, 99) >= idle_out);
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_in) begin
        nxt = pending_items.pop_front();
        n_sent++;
        in_tvalid <= 1'b1;
        in_tdata  <= {4'h0, nxt.data, nxt.is_wr, nxt.port};
        in_tuser  <= nxt.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check results, then predict for the item accepted at this edge
  always @(posedge clk) begin : watch
    pit_item_t   it;
    pit_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          flag_mismatch("unexpected result", 0, int'(out_tdata));
        end else begin
          want = due_results.pop_front();
          if (out_tdata[7:0] !== want.rd)
            flag_mismatch("read_byte", int'(want.rd), int'(out_tdata[7:0]));
          if (out_tdata[8] !== want.irq)
            flag_mismatch("irq_pulse", int'(want.irq), int'(out_tdata[8]));
        end
      end
      if (in_tvalid && in_tready) begin
        it = '{op: in_tuser[0], port: in_tdata[2:0], is_wr: in_tdata[3], data: in_tdata[11:4]};
        due_results.push_back(timer_apply(it));
        n_accepted++;
      end
    end
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stim
    int         ch;
    int         kind;
    int         n;
    int         rand_start;
    int         total;
    logic [7:0] lo;
    logic [7:0] hi;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    in_taken = 1'b0;
    n_sent = 0;
    n_accepted = 0;
    err_cnt = 0;
    for (int c = 0; c < pitc_pkg::MAX_CH; c++) begin
      reload_q[c] = pitc_pkg::COUNT_MAX;
      count_q[c] = pitc_pkg::COUNT_MAX;
      mode_q[c] = pitc_pkg::MODE_ONESHOT;
      lsb_hold[c] = 8'd0;
      want_msb[c] = 1'b0;
      want_lsb[c] = 1'b1;
      snap_q[c] = 16'd0;
      status_due[c] = 1'b0;
      fired_q[c] = 1'b0;
      armed_q[c] = 1'b0;
    end

    // Directed items
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CNT0, DIR_RD, 8'h00);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CTRL, DIR_RD, 8'hFF);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_MISC, DIR_RD, 8'h00);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CTRL, DIR_WR,
        {2'd0, ACC_LOHI, pitc_pkg::MODE_ONESHOT, 1'b0});
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CNT0, DIR_WR, 8'h02);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CNT0, DIR_WR, 8'h00);
    for (int i = 0; i < 4; i++) put(pitc_pkg::OP_TICK, 3'd7, DIR_WR, 8'hFF);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CTRL, DIR_WR,
        {2'd2, ACC_LOHI, pitc_pkg::MODE_SQUARE, 1'b0});
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CNT2, DIR_WR, 8'h00);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CNT2, DIR_WR, 8'h00);  // zero reload: full count
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_MISC, DIR_RD, 8'hFF);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CTRL, DIR_WR,
        {pitc_pkg::SEL_READBACK, 1'b0, 1'b0, 3'b111, 1'b0});
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CNT1, DIR_RD, 8'h00);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CNT1, DIR_RD, 8'h00);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CNT1, DIR_RD, 8'h00);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CTRL, DIR_WR,
        {2'd1, pitc_pkg::ACC_LATCH, 3'd7, 1'b1});
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_MISC, DIR_WR, 8'hFF);
    put(pitc_pkg::OP_ACCESS, 3'd5, DIR_RD, 8'h00);
    put(pitc_pkg::OP_ACCESS, 3'd7, DIR_WR, 8'hFF);
    put(pitc_pkg::OP_ACCESS, 3'd6, DIR_RD, 8'hFF);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CTRL, DIR_WR, 8'hFF);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CTRL, DIR_WR, {2'd1, 2'b01, 3'd7, 1'b0});
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CNT1, DIR_RD, 8'h00);
    put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CNT1, DIR_RD, 8'h00);

    // Random part: mostly well-formed programming, tick, latch and read sequences
    rand_start = pending_items.size();
    while (pending_items.size() < rand_start + N_RANDOM) begin
      kind = $urandom_range(0, 99);
      ch = $urandom_range(0, 2);
      if (kind < 18) begin
        put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CTRL, DIR_WR,
            ctrl_word(2'(ch), 2'($urandom_range(1, 3)),
                      $urandom_range(0, 1) ? 3'($urandom)
                                           : ($urandom_range(0, 1) ? pitc_pkg::MODE_ONESHOT
                                                                   : pitc_pkg::MODE_SQUARE)));
        lo = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
        hi = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h00;
        put(pitc_pkg::OP_ACCESS, 3'(ch), DIR_WR, lo);
        put(pitc_pkg::OP_ACCESS, 3'(ch), DIR_WR, hi);
      end else if (kind < 45) begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) put_tick();
      end else if (kind < 60) begin
        put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CTRL, DIR_WR,
            ctrl_word(2'(ch), pitc_pkg::ACC_LATCH, 3'($urandom)));
        put(pitc_pkg::OP_ACCESS, 3'(ch), DIR_RD, 8'($urandom));
        if ($urandom_range(0, 5) != 0) put(pitc_pkg::OP_ACCESS, 3'(ch), DIR_RD, 8'($urandom));
      end else if (kind < 70) begin
        put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_CTRL, DIR_WR,
            {pitc_pkg::SEL_READBACK, 6'($urandom)});
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          put(pitc_pkg::OP_ACCESS, 3'($urandom_range(0, 2)), DIR_RD, 8'($urandom));
      end else if (kind < 80) begin
        put(pitc_pkg::OP_ACCESS, pitc_pkg::PORT_MISC, DIR_RD, 8'($urandom));
      end else begin
        put(1'($urandom), 3'($urandom), 1'($urandom), 8'($urandom));
      end
    end
    total = pending_items.size();
    bound1 = rand_start + (total - rand_start) / 3;
    bound2 = rand_start + 2 * (total - rand_start) / 3;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < total) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
